[rtl/modbus_rtu_slave_responder_top_defines.svh]
// Assertion macros used by the port checker
`ifndef MODBUS_RTU_SLAVE_RESPONDER_TOP_DEFINES_SVH
`define MODBUS_RTU_SLAVE_RESPONDER_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset
`define MRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset
`define MRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/mrs_pkg.sv]
`timescale 1ns / 1ps
package mrs_pkg;
  localparam int NumRegs     = 64;
  localparam int FrameBytes  = 64;
  localparam int MaxReadRegs = 29;
  localparam int RegAw       = $clog2(NumRegs);
  localparam int BufAw       = $clog2(FrameBytes);
  localparam int LenW        = BufAw + 1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  FcRead   = 8'h03;
  localparam logic [7:0]  FcWrite1 = 8'h06;
  localparam logic [7:0]  FcWriteN = 8'h10;
  localparam logic [1:0]  RegSlaveAddr = 2'd0;

  // Controller states
  typedef enum logic [3:0] {
    ST_RX,        // wait for a received byte
    ST_RXCRC,     // fold that byte into the running CRC
    ST_HDR,       // read header bytes out of the buffer
    ST_CHECK,     // judge the frame
    ST_WRITE,     // write FC10 registers, one per pass
    ST_TXLOAD,    // fetch next reply byte
    ST_TXCRC,     // fold the reply byte into the reply CRC
    ST_TXOUT,     // present reply byte on the output register
    ST_TXCRCLO,   // send CRC low byte
    ST_TXCRCHI    // send CRC high byte
  } mrs_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       rx_store;     // buffer in byte, start CRC step
    logic       crc_step;     // one CRC bit step
    logic       crc_init;     // reset the CRC
    logic       crc_load_b;   // xor selected byte into the CRC
    logic       hdr_rd;       // read buffer at hdr index
    logic       hdr_clr;      // clear header index
    logic       frame_clr;    // clear length and overflow
    logic       wr_single;    // FC06 write
    logic       wr_multi;     // FC10 write step
    logic       tx_first;     // start reply index
    logic       tx_fetch;     // fetch reply byte at tx index
    logic       out_load;     // load output with fetched byte
    logic       out_crclo;    // load output with CRC low byte
    logic       out_crchi;    // load output with CRC high byte
  } mrs_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic       frame_end;    // latched mark of the last byte
    logic       hdr_done;     // header fully captured
    logic       frame_ok;     // address, length, CRC good
    logic       do_read;      // FC03 valid
    logic       do_wr1;       // FC06 valid
    logic       do_wrn;       // FC10 valid
    logic       wr_done;      // FC10 write finished
    logic       tx_end;       // all body bytes sent
    logic       out_busy;     // output register still full
  } mrs_sts_t;
endpackage

[rtl/mrs_ctrl.sv]
`timescale 1ns / 1ps
module mrs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  mrs_pkg::mrs_sts_t sts,
  input  logic             crc_bit_last,
  output mrs_pkg::mrs_cmd_t cmd,
  output logic             in_ready
);
  mrs_pkg::mrs_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mrs_pkg::ST_RX;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrs_pkg::ST_RX:      if (in_fire) state_nxt = mrs_pkg::ST_RXCRC;
      mrs_pkg::ST_RXCRC: begin
        if (crc_bit_last) state_nxt = sts.frame_end ? mrs_pkg::ST_HDR : mrs_pkg::ST_RX;
      end
      mrs_pkg::ST_HDR:     if (sts.hdr_done) state_nxt = mrs_pkg::ST_CHECK;
      mrs_pkg::ST_CHECK: begin
        if (!sts.frame_ok) state_nxt = mrs_pkg::ST_RX;
        else if (sts.do_wrn) state_nxt = mrs_pkg::ST_WRITE;
        else if (sts.do_read || sts.do_wr1) state_nxt = mrs_pkg::ST_TXLOAD;
        else state_nxt = mrs_pkg::ST_RX;
      end
      mrs_pkg::ST_WRITE:   if (sts.wr_done) state_nxt = mrs_pkg::ST_TXLOAD;
      mrs_pkg::ST_TXLOAD: begin
        if (sts.tx_end) state_nxt = mrs_pkg::ST_TXCRCLO;
        else state_nxt = mrs_pkg::ST_TXCRC;
      end
      mrs_pkg::ST_TXCRC:   if (crc_bit_last) state_nxt = mrs_pkg::ST_TXOUT;
      mrs_pkg::ST_TXOUT:   if (!sts.out_busy) state_nxt = mrs_pkg::ST_TXLOAD;
      mrs_pkg::ST_TXCRCLO: if (!sts.out_busy) state_nxt = mrs_pkg::ST_TXCRCHI;
      mrs_pkg::ST_TXCRCHI: if (!sts.out_busy) state_nxt = mrs_pkg::ST_RX;
      default:             state_nxt = mrs_pkg::ST_RX;
    endcase
  end

  // Command decode
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      mrs_pkg::ST_RX: begin
        in_ready = 1'b1;
        cmd.rx_store = in_fire;
      end
      mrs_pkg::ST_RXCRC: cmd.crc_step = 1'b1;
      mrs_pkg::ST_HDR:   cmd.hdr_rd = 1'b1;
      mrs_pkg::ST_CHECK: begin
        cmd.hdr_clr = 1'b1;
        cmd.wr_single = sts.frame_ok && sts.do_wr1;
        cmd.tx_first = 1'b1;
        cmd.crc_init = 1'b1;
        if (!sts.frame_ok || !(sts.do_read || sts.do_wr1 || sts.do_wrn))
          cmd.frame_clr = 1'b1;
      end
      mrs_pkg::ST_WRITE:  cmd.wr_multi = 1'b1;
      mrs_pkg::ST_TXLOAD: begin
        cmd.tx_fetch = !sts.tx_end;
        cmd.crc_load_b = !sts.tx_end;
      end
      mrs_pkg::ST_TXCRC:  cmd.crc_step = 1'b1;
      mrs_pkg::ST_TXOUT:  cmd.out_load = !sts.out_busy;
      mrs_pkg::ST_TXCRCLO: cmd.out_crclo = !sts.out_busy;
      mrs_pkg::ST_TXCRCHI: begin
        cmd.out_crchi = !sts.out_busy;
        cmd.frame_clr = !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end
endmodule

[rtl/mrs_dp.sv]
`timescale 1ns / 1ps
module mrs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mrs_pkg::mrs_cmd_t cmd,
  input  logic [7:0]        rx_byte,
  input  logic              rx_end,
  input  logic [7:0]        slave_addr,
  input  logic              out_ready,
  output mrs_pkg::mrs_sts_t sts,
  output logic              crc_bit_last,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  localparam int LenW = mrs_pkg::LenW;
  localparam int BufAw = mrs_pkg::BufAw;
  localparam int RegAw = mrs_pkg::RegAw;

  // Frame buffer, one write and one read port
  logic [7:0] fbuf [mrs_pkg::FrameBytes];
  logic [7:0] frd_r;

  logic [LenW-1:0] len_r;
  logic            ovf_r;
  logic            end_r;
  logic [15:0]     crc_r;
  logic [2:0]      bit_r;
  logic [15:0]     crc_hist_r;  // CRC before last two bytes
  logic [15:0]     crc_prev_r;  // CRC before last byte

  // Register file with per-entry valid bits
  logic [15:0]     rf [mrs_pkg::NumRegs];
  logic [mrs_pkg::NumRegs-1:0] rf_vld_r;
  logic [15:0]     rf_rd_r;

  // Header capture
  logic [3:0]      hidx_r;
  logic            hrd_pend_r;
  logic [3:0]      hcap_r;
  logic [7:0]      h_r [7];   // bytes 0..6
  logic [7:0]      lastb_r, prevb_r;

  // Write and reply sequencing
  logic [LenW-1:0] widx_r;
  logic [RegAw:0]  wcnt_r;
  logic [1:0]      wph_r;
  logic [7:0]      whi_r;
  logic [6:0]      tidx_r;
  logic [6:0]      tlen_r;
  logic            mode_rd_r;
  logic [7:0]      tbyte_r;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;

  logic [16:0] start_q, qty_q;
  logic [BufAw-1:0] rd_addr;
  logic [RegAw-1:0] rf_addr;
  logic [7:0]  crc_xb;
  logic [7:0]  body_b;
  logic [6:0]  tdat_idx;     // reply index relative to first data byte

  assign start_q = {1'b0, h_r[2], h_r[3]};
  assign qty_q   = {1'b0, h_r[4], h_r[5]};
  assign tdat_idx = tidx_r - 7'd3;

  // Buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.rx_store && len_r < LenW'(mrs_pkg::FrameBytes))
      fbuf[len_r[BufAw-1:0]] <= rx_byte;
    frd_r <= fbuf[rd_addr];
  end

  always_comb begin
    if (cmd.wr_multi) rd_addr = widx_r[BufAw-1:0];
    else if (cmd.tx_fetch) rd_addr = tidx_r[BufAw-1:0];
    else rd_addr = hidx_r[BufAw-1:0] ;
  end

  // Frame length, overflow and end mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; ovf_r <= 1'b0; end_r <= 1'b0;
    end else if (cmd.frame_clr) begin
      len_r <= '0; ovf_r <= 1'b0; end_r <= 1'b0;
    end else if (cmd.rx_store) begin
      end_r <= rx_end;
      if (len_r < LenW'(mrs_pkg::FrameBytes)) len_r <= len_r + 1'b1;
      else ovf_r <= 1'b1;
    end
  end

  // CRC: rx bytes fold in one bit step at a time; history kept for the trailer
  assign crc_xb = cmd.rx_store ? rx_byte : body_b;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mrs_pkg::CrcInit; bit_r <= '0;
      crc_hist_r <= mrs_pkg::CrcInit; crc_prev_r <= mrs_pkg::CrcInit;
    end else if (cmd.crc_init || (cmd.frame_clr && !cmd.out_crchi)) begin
      crc_r <= mrs_pkg::CrcInit; bit_r <= '0;
      crc_hist_r <= mrs_pkg::CrcInit; crc_prev_r <= mrs_pkg::CrcInit;
    end else if (cmd.out_crchi) begin
      crc_r <= mrs_pkg::CrcInit; bit_r <= '0;
      crc_hist_r <= mrs_pkg::CrcInit; crc_prev_r <= mrs_pkg::CrcInit;
    end else if (cmd.rx_store || cmd.crc_load_b) begin
      if (cmd.rx_store && len_r < LenW'(mrs_pkg::FrameBytes)) begin
        crc_hist_r <= crc_prev_r;
        crc_prev_r <= crc_r;
      end
      crc_r <= crc_r ^ {8'h00, crc_xb};
      bit_r <= '0;
    end else if (cmd.crc_step) begin
      crc_r <= crc_r[0] ? ((crc_r >> 1) ^ mrs_pkg::CrcPoly) : (crc_r >> 1);
      bit_r <= bit_r + 1'b1;
    end
  end
  assign crc_bit_last = (bit_r == 3'd7);

  // Last two received bytes for the trailer check
  always_ff @(posedge clk) begin
    if (cmd.rx_store && len_r < LenW'(mrs_pkg::FrameBytes)) begin
      prevb_r <= lastb_r;
      lastb_r <= rx_byte;
    end
  end

  // Header read: seven bytes through the buffer read port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidx_r <= '0; hrd_pend_r <= 1'b0; hcap_r <= '0;
    end else if (cmd.hdr_clr) begin
      hidx_r <= '0; hrd_pend_r <= 1'b0; hcap_r <= '0;
    end else if (cmd.hdr_rd) begin
      if (hidx_r < 4'd7) hidx_r <= hidx_r + 1'b1;
      hrd_pend_r <= (hidx_r < 4'd7);
      if (hrd_pend_r) hcap_r <= hcap_r + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.hdr_rd && hrd_pend_r && hcap_r < 4'd7) h_r[hcap_r[2:0]] <= frd_r;
  end
  assign sts.hdr_done = (hcap_r == 4'd7);

  // Frame judgement
  logic crc_good, len_ge8;
  assign crc_good = (prevb_r == crc_hist_r[7:0]) && (lastb_r == crc_hist_r[15:8]);
  assign len_ge8 = (len_r >= LenW'(8));
  assign sts.frame_end = end_r;
  assign sts.frame_ok = !ovf_r && (len_r >= LenW'(4)) && (h_r[0] == slave_addr)
                        && crc_good && len_ge8;
  assign sts.do_read = (h_r[1] == mrs_pkg::FcRead) && (len_r == LenW'(8))
                       && (qty_q >= 17'd1) && (qty_q <= 17'(mrs_pkg::MaxReadRegs))
                       && (start_q + qty_q <= 17'(mrs_pkg::NumRegs));
  assign sts.do_wr1 = (h_r[1] == mrs_pkg::FcWrite1) && (len_r == LenW'(8))
                      && (start_q < 17'(mrs_pkg::NumRegs));
  assign sts.do_wrn = (h_r[1] == mrs_pkg::FcWriteN) && (qty_q >= 17'd1)
                      && ({9'd0, h_r[6]} == {qty_q[15:0], 1'b0})
                      && ({10'd0, len_r} == 17'd9 + {9'd0, h_r[6]})
                      && (start_q + qty_q <= 17'(mrs_pkg::NumRegs));

  // Register file access; reply data byte k (from 3) maps to register start + (k-3)/2
  always_comb begin
    if (cmd.wr_single) rf_addr = start_q[RegAw-1:0];
    else if (cmd.wr_multi) rf_addr = start_q[RegAw-1:0] + wcnt_r[RegAw-1:0];
    else rf_addr = start_q[RegAw-1:0] + tdat_idx[RegAw:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rf_vld_r <= '0;
    else if (cmd.wr_single || (cmd.wr_multi && wph_r == 2'd2))
      rf_vld_r[rf_addr] <= 1'b1;
  end
  // Registered read; address holds through the CRC bit steps before each fetch
  always_ff @(posedge clk) begin
    if (cmd.wr_single) rf[rf_addr] <= qty_q[15:0];
    else if (cmd.wr_multi && wph_r == 2'd2) rf[rf_addr] <= {whi_r, frd_r};
    rf_rd_r <= rf_vld_r[rf_addr] ? rf[rf_addr] : 16'h0000;
  end

  // FC10 write sequencer: read high byte, read low byte, write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0; wcnt_r <= '0; wph_r <= '0;
    end else if (cmd.hdr_clr) begin
      widx_r <= LenW'(7); wcnt_r <= '0; wph_r <= '0;
    end else if (cmd.wr_multi) begin
      case (wph_r)
        2'd0: begin widx_r <= widx_r + 1'b1; wph_r <= 2'd1; end
        2'd1: begin widx_r <= widx_r + 1'b1; whi_r <= frd_r; wph_r <= 2'd2; end
        2'd2: begin wcnt_r <= wcnt_r + 1'b1; wph_r <= 2'd0; end
        default: wph_r <= 2'd0;
      endcase
    end
  end
  assign sts.wr_done = (wcnt_r == qty_q[RegAw:0]) && (wph_r == 2'd0) && (wcnt_r != '0);

  // Reply body: echo header bytes 0..5, or address, code, count, data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tidx_r <= '0; tlen_r <= '0; mode_rd_r <= 1'b0;
    end else if (cmd.tx_first) begin
      tidx_r <= '0;
      mode_rd_r <= sts.do_read;
      tlen_r <= sts.do_read ? (7'd3 + {qty_q[5:0], 1'b0}) : 7'd6;
    end else if (cmd.tx_fetch) begin
      tidx_r <= tidx_r + 1'b1;
    end
  end
  assign sts.tx_end = (tidx_r == tlen_r);

  // Byte selection: header bytes come from capture, data from register file
  always_comb begin
    if (!mode_rd_r || tidx_r < 7'd2) body_b = h_r[tidx_r[2:0]];
    else if (tidx_r == 7'd2) body_b = {qty_q[6:0], 1'b0};
    else if (tidx_r[0]) body_b = rf_rd_r[15:8];
    else body_b = rf_rd_r[7:0];
  end
  always_ff @(posedge clk) begin
    if (cmd.tx_fetch) tbyte_r <= body_b;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load || cmd.out_crclo || cmd.out_crchi) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin out_byte_r <= tbyte_r; out_last_r <= 1'b0; end
    else if (cmd.out_crclo) begin out_byte_r <= crc_r[7:0]; out_last_r <= 1'b0; end
    else if (cmd.out_crchi) begin out_byte_r <= crc_r[15:8]; out_last_r <= 1'b1; end
  end
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_last = out_last_r;
endmodule

[rtl/modbus_rtu_slave_responder_top.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Handshake              | Payload
// in_      | in  | in_tvalid / in_tready   | tdata = rx_byte, tlast = frame_end
// out_     | out | out_tvalid / out_tready | tdata = tx_byte, tlast = tx_last
// cfg_     | in  | APB, pready always high | reg 0 slave_address at 0x0
// Each received beat is written to the buffer, then folded into the bitwise CRC.
// At frame end the header is read back from the buffer;
// FC10 then writes each register in turn, and each reply byte passes
// through the shared CRC unit plus the output register.
// Reset (rst_n low, synchronous) clears control, slave_address to 1 and
// the register-file valid bits. A stalled out_tready holds the sequencer.
module modbus_rtu_slave_responder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  mrs_pkg::mrs_cmd_t cmd;
  mrs_pkg::mrs_sts_t sts;
  logic crc_bit_last;
  logic [7:0] slave_addr_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) slave_addr_r <= 8'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == mrs_pkg::RegSlaveAddr)
      slave_addr_r <= cfg_pwdata[7:0];
  end
  assign cfg_prdata = (cfg_paddr == mrs_pkg::RegSlaveAddr) ? {24'd0, slave_addr_r} : 32'd0;

  mrs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .sts(sts), .crc_bit_last(crc_bit_last), .cmd(cmd), .in_ready(in_tready)
  );

  mrs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .rx_byte(in_tdata), .rx_end(in_tlast),
    .slave_addr(slave_addr_r), .out_ready(out_tready), .sts(sts),
    .crc_bit_last(crc_bit_last), .out_valid(out_tvalid), .out_byte(out_tdata),
    .out_last(out_tlast)
  );
endmodule

[rtl/mrs_checker.sv]
`timescale 1ns / 1ps
`include "modbus_rtu_slave_responder_top_defines.svh"
module mrs_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  // No input taken while a reply is still being sent (only the last beat may linger)
  `MRS_ASSERT_IMPL(a_no_rx_during_tx, out_tvalid && !out_tlast, !in_tready)
  // Stalled output beat holds
  `MRS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Input not accepted in the cycle right after a beat is taken
  `MRS_ASSERT_NEXT(a_rx_crc_busy, in_tvalid && in_tready, !in_tready)
endmodule

bind modbus_rtu_slave_responder_top mrs_port_checker u_mrs_port_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

[test/mrs_checker.sv]
`timescale 1ns / 1ps
module mrs_checker
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,   // [7:0] tx_byte
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  // Shadow of the slave state
  logic [7:0]  rx_buf [FrameBytes];
  int unsigned rx_len;
  bit          rx_ovf;
  logic [15:0] hold_regs [NumRegs];
  logic [7:0]  own_addr;
  reply_beat_t reply_q [$];

  assign pending = reply_q.size();

  function automatic logic [15:0] crc16(input logic [7:0] m [$]);
    logic [15:0] c;
    c = CrcInit;
    foreach (m[i]) begin
      c ^= {8'h00, m[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Judge the buffered frame; queue the reply it should produce
  function automatic void answer_frame();
    logic [7:0]  f [$];
    logic [7:0]  msg [$];
    logic [15:0] c;
    int unsigned start, qty;
    if (rx_ovf || rx_len < 4) return;
    if (rx_buf[0] != own_addr) return;
    for (int i = 0; i < rx_len - 2; i++) f.push_back(rx_buf[i]);
    c = crc16(f);
    if (rx_buf[rx_len-2] != c[7:0] || rx_buf[rx_len-1] != c[15:8]) return;
    if (rx_len < 8) return;
    start = {rx_buf[2], rx_buf[3]};
    qty   = {rx_buf[4], rx_buf[5]};
    case (rx_buf[1])
      FcRead: begin
        if (rx_len != 8 || qty < 1 || qty > MaxReadRegs || start + qty > NumRegs) return;
        msg = {rx_buf[0], rx_buf[1], 8'(qty * 2)};
        for (int i = 0; i < qty; i++) begin
          msg.push_back(hold_regs[start+i][15:8]);
          msg.push_back(hold_regs[start+i][7:0]);
        end
      end
      FcWrite1: begin
        if (rx_len != 8 || start >= NumRegs) return;
        hold_regs[start] = qty[15:0];
        for (int i = 0; i < 6; i++) msg.push_back(rx_buf[i]);
      end
      FcWriteN: begin
        if (rx_len < 9 || qty < 1 || rx_buf[6] != qty * 2 || rx_len != 9 + rx_buf[6] ||
            start + qty > NumRegs) return;
        for (int i = 0; i < qty; i++)
          hold_regs[start+i] = {rx_buf[7+2*i], rx_buf[8+2*i]};
        for (int i = 0; i < 6; i++) msg.push_back(rx_buf[i]);
      end
      default: return;
    endcase
    c = crc16(msg);
    msg.push_back(c[7:0]);
    msg.push_back(c[15:8]);
    foreach (msg[i]) reply_q.push_back('{data: msg[i], last: (i == msg.size() - 1)});
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_len   = 0;
      rx_ovf   = 0;
      own_addr = 8'd1;
      foreach (hold_regs[i]) hold_regs[i] = '0;
      reply_q.delete();
    end else begin
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == RegSlaveAddr)
        own_addr = cfg_pwdata[7:0];
      // reply beat
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected reply beat %02h", out_tdata));
        end else begin
          reply_beat_t e;
          e = reply_q.pop_front();
          if (out_tdata !== e.data)
            report_mismatch($sformatf("tx_byte %02h, want %02h", out_tdata, e.data));
          if (out_tlast !== e.last)
            report_mismatch($sformatf("tx_last %b, want %b", out_tlast, e.last));
        end
      end
      // received beat
      if (in_tvalid && in_tready) begin
        if (rx_len < FrameBytes) begin
          rx_buf[rx_len] = in_tdata;
          rx_len++;
        end else begin
          rx_ovf = 1;
        end
        if (in_tlast) begin
          answer_frame();
          rx_len = 0;
          rx_ovf = 0;
        end
      end
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import mrs_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int Drain      = 400;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] rx_byte
  logic        in_tlast = 0;
  logic        out_tvalid, out_tready = 0;
  logic [7:0]  out_tdata;        // [7:0] tx_byte
  logic        out_tlast;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic        cfg_pready;
  int          fails, pending;
  int          src_idle = 0, dst_idle = 0;
  int          sent = 0;
  int          cycles = 0;
  logic [7:0]  cur_addr = 8'd1;

  modbus_rtu_slave_responder_top dut (.*);

  mrs_checker chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // receiver side stalls
  always @(negedge clk) out_tready = rst_n && ($urandom_range(99) >= dst_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add_crc(ref logic [7:0] fr [$]);
    logic [15:0] c;
    c = CrcInit;
    foreach (fr[i]) begin
      c ^= {8'h00, fr[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
  endfunction

  task automatic send_frame(input logic [7:0] fr [$]);
    bit took;
    foreach (fr[i]) begin
      while ($urandom_range(99) < src_idle) begin
        in_tvalid = 0;
        @(negedge clk);
      end
      in_tvalid = 1;
      in_tdata  = fr[i];
      in_tlast  = (i == fr.size() - 1);
      // in_tready only moves at a rising edge, so its value now decides the next one
      do begin
        took = in_tready;
        @(negedge clk);
      end while (!took);
      sent++;
    end
    in_tvalid = 0;
  endtask

  task automatic write_addr(input logic [7:0] a);
    @(negedge clk);
    cfg_psel = 1; cfg_pwrite = 1; cfg_paddr = RegSlaveAddr; cfg_pwdata = {24'h0, a};
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    cur_addr = a;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
  endtask

  // Build and send one frame of the given sort
  task automatic frame_of(input int sort, input logic [15:0] start, input logic [15:0] qty,
                          input int words);
    logic [7:0] fr [$];
    case (sort)
      0: fr = {cur_addr, FcRead, start[15:8], start[7:0], qty[15:8], qty[7:0]};
      1: fr = {cur_addr, FcWrite1, start[15:8], start[7:0], qty[15:8], qty[7:0]};
      default: begin
        fr = {cur_addr, FcWriteN, start[15:8], start[7:0], qty[15:8], qty[7:0],
              8'(words * 2)};
        repeat (2 * words) fr.push_back(8'($urandom));
      end
    endcase
    add_crc(fr);
    send_frame(fr);
  endtask

  task automatic random_frame();
    logic [7:0] fr [$];
    int         pick, q, s, n;
    pick = $urandom_range(99);
    q = $urandom_range(1, 29);
    s = $urandom_range(0, NumRegs - q);
    if (pick < 25) begin
      frame_of(0, 16'(s), 16'(q), 0);
    end else if (pick < 45) begin
      frame_of(1, 16'($urandom_range(0, NumRegs - 1)), 16'($urandom), 0);
    end else if (pick < 65) begin
      q = $urandom_range(1, 6);
      frame_of(2, 16'($urandom_range(0, NumRegs - q)), 16'(q), q);
    end else if (pick < 72) begin
      // out of range or bad quantity
      case ($urandom_range(3))
        0: frame_of(0, 16'($urandom_range(36, 63)), 16'd29, 0);
        1: frame_of(0, 16'd0, 16'($urandom_range(0, 1) ? 0 : $urandom_range(30, 65535)), 0);
        2: frame_of(1, 16'($urandom_range(64, 65535)), 16'($urandom), 0);
        default: frame_of(2, 16'd62, 16'd3, 3);
      endcase
    end else if (pick < 80) begin
      // corrupted CRC
      fr = {cur_addr, FcWrite1, 8'h00, 8'($urandom_range(63)), 8'($urandom), 8'($urandom)};
      add_crc(fr);
      fr[7] ^= 8'(1 << $urandom_range(7));
      send_frame(fr);
    end else if (pick < 86) begin
      // wrong address or unknown function code
      fr = {$urandom_range(1) ? cur_addr : 8'(cur_addr + $urandom_range(1, 255)),
            8'($urandom), 8'h00, 8'($urandom_range(63)), 8'h00, 8'h01};
      add_crc(fr);
      send_frame(fr);
    end else if (pick < 98) begin
      n = $urandom_range(1, 12);
      repeat (n) fr.push_back(8'($urandom));
      if ($urandom_range(1)) fr[0] = cur_addr;
      send_frame(fr);
    end else begin
      // more bytes than the buffer holds, and more data bytes than its byte count gives
      fr = {cur_addr, FcWriteN, 8'h00, 8'h00, 8'h00, 8'd28, 8'd56};
      repeat (56 + $urandom_range(1, 4)) fr.push_back(8'($urandom));
      add_crc(fr);
      send_frame(fr);
    end
  endtask

  initial begin
    logic [7:0] fr [$];
    repeat (8) @(negedge clk);
    rst_n = 1;
    write_addr(8'd1);

    // directed: field extremes, each code, short/overflow/bad frames
    frame_of(1, 16'd63, 16'hFFFF, 0);
    frame_of(2, 16'd0, 16'd2, 2);
    frame_of(0, 16'd35, 16'd29, 0);
    frame_of(0, 16'd63, 16'd1, 0);
    fr = {8'd1, FcRead, 8'h00};
    send_frame(fr);
    fr = {8'd2, FcRead, 8'h00, 8'h00, 8'h00, 8'h01};
    add_crc(fr);
    send_frame(fr);
    fr = {8'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
    add_crc(fr);
    send_frame(fr);
    fr = {};
    repeat (66) fr.push_back(8'hFF);
    send_frame(fr);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      src_idle = (p == 0) ? 38 : (p == 1) ? 63 : 0;
      dst_idle = (p == 0) ? 63 : (p == 1) ? 38 : 0;
      write_addr(p == 0 ? 8'd247 : p == 1 ? 8'($urandom_range(2, 246)) : 8'd1);
      while (sent < 120 + 110 * (p + 1)) random_frame();
      wait_idle();
    end
    // unusual addresses outside the legal range
    write_addr(8'd0);
    frame_of(1, 16'd5, 16'h1234, 0);
    wait_idle();
    write_addr(8'd255);
    frame_of(0, 16'd0, 16'd8, 0);
    wait_idle();

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
